// File: src/nr_ldpc_segmentation_params_defines.svh
// ----------------------------------------------------------------------------
// nr ldpc segmentation params assertion macros
// shared property forms for the checker, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef NR_LDPC_SEGMENTATION_PARAMS_DEFINES_SVH
`define NR_LDPC_SEGMENTATION_PARAMS_DEFINES_SVH

// same-cycle implication, off during reset
`define NLS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nr ldpc segmentation params check failed");

// next-cycle implication, off during reset
`define NLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nr ldpc segmentation params check failed");

// next-cycle implication, also checked during reset
`define NLS_ASSERT_NEXT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("nr ldpc segmentation params reset check failed");

`endif

// File: src/nrldpcseg_pkg.sv
// ----------------------------------------------------------------------------
// nrldpcseg_pkg
// field widths, limits, lifting size table and result layout for the
// nr ldpc segmentation parameter block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nrldpcseg_pkg;

    localparam int TB_W       = 20;
    localparam int SEG_W      = 21;
    localparam int CRC_W      = 5;
    localparam int BG_W       = 2;
    localparam int NSEG_W     = 10;
    localparam int KP_W       = 14;
    localparam int KB_W       = 5;
    localparam int LIFT_W     = 9;
    localparam int SET_W      = 4;
    localparam int BLK_W      = 14;
    localparam int FILL_W     = 14;
    localparam int CODED_W    = 15;
    localparam int OLEN_W     = 31;
    localparam int PAD_W      = 5;
    localparam int OUT_W      = 128;
    localparam int NUM_LIFTS  = 51;
    localparam int LIFT_IDX_W = 6;

    localparam logic [TB_W-1:0] TB_CRC_LIMIT        = 20'd3824;
    localparam logic [TB_W-1:0] BG2_SIZE_LIMIT      = 20'd293;
    localparam logic [TB_W-1:0] BG2_RATE_SIZE_LIMIT = 20'd3825;

    localparam int RATE_BG2_NUM = 67;
    localparam int RATE_BG2_DEN = 100;

    localparam logic [CRC_W-1:0] CRC_SHORT = 5'd16;
    localparam logic [CRC_W-1:0] CRC_LONG  = 5'd24;

    localparam logic [BG_W-1:0] BG_ONE = 2'd1;
    localparam logic [BG_W-1:0] BG_TWO = 2'd2;

    localparam logic [KP_W-1:0] KCB_BG1 = 14'd8448;
    localparam logic [KP_W-1:0] KCB_BG2 = 14'd3840;

    localparam logic [SEG_W-1:0] KB_LIMIT_10 = 21'd640;
    localparam logic [SEG_W-1:0] KB_LIMIT_9  = 21'd560;
    localparam logic [SEG_W-1:0] KB_LIMIT_8  = 21'd192;

    localparam logic [KB_W-1:0] KB_BG1 = 5'd22;
    localparam logic [KB_W-1:0] KB_10  = 5'd10;
    localparam logic [KB_W-1:0] KB_9   = 5'd9;
    localparam logic [KB_W-1:0] KB_8   = 5'd8;
    localparam logic [KB_W-1:0] KB_6   = 5'd6;

    localparam int BLK_MUL_BG1   = 22;
    localparam int BLK_MUL_BG2   = 10;
    localparam int CODED_MUL_BG1 = 66;
    localparam int CODED_MUL_BG2 = 50;

    localparam logic [OLEN_W-1:0] OUT_LEN_MAX = 31'h7FFF_FFFF;

    localparam logic [LIFT_W-1:0] LIFT_TABLE [NUM_LIFTS] = '{
        9'd2,   9'd3,   9'd4,   9'd5,   9'd6,   9'd7,   9'd8,   9'd9,   9'd10,
        9'd11,  9'd12,  9'd13,  9'd14,  9'd15,  9'd16,  9'd18,  9'd20,  9'd22,
        9'd24,  9'd26,  9'd28,  9'd30,  9'd32,  9'd36,  9'd40,  9'd44,  9'd48,
        9'd52,  9'd56,  9'd60,  9'd64,  9'd72,  9'd80,  9'd88,  9'd96,  9'd104,
        9'd112, 9'd120, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd208, 9'd224,
        9'd240, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384
    };

    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        logic [OLEN_W-1:0]  out_len;
        logic [CODED_W-1:0] coded_len;
        logic [FILL_W-1:0]  filler_bits;
        logic [BLK_W-1:0]   block_size;
        logic [SET_W-1:0]   lift_set;
        logic [LIFT_W-1:0]  lift_size;
        logic [KB_W-1:0]    info_cols;
        logic [KP_W-1:0]    seg_bits;
        logic [NSEG_W-1:0]  num_segments;
        logic [BG_W-1:0]    base_graph;
        logic [CRC_W-1:0]   crc_len;
    } res_t;

    // set index from the odd part of z: a = 2*set - 1
    function automatic logic [SET_W-1:0] lift_set_of(input logic [LIFT_W-1:0] z);
        logic [LIFT_W-1:0] odd;
        logic [LIFT_W:0]   sum;
        odd = z;
        for (int i = 0; i < LIFT_W - 1; i++) begin
            if (odd[0] == 1'b0 && odd != '0) begin
                odd = odd >> 1;
            end
        end
        sum = {1'b0, odd} + {{LIFT_W{1'b0}}, 1'b1};
        return sum[SET_W:1];
    endfunction

endpackage

`default_nettype wire

// File: src/nr_ldpc_segmentation_params.sv
// ----------------------------------------------------------------------------
// nr ldpc segmentation params
// derives crc length, base graph, segmentation, lifting size and output length
// for one transport block per request
//
// s_ channel: one beat per request, tdata = tb_size then rate (rate * 2^F)
// m_ channel: one beat per request with all derived fields
// the block takes one request at a time; s_tready is high only when idle
// work runs through one shared restoring divider, one quotient bit a cycle:
//   output length division (skipped for a zero rate)
//   segment count and segment size divisions, only when
//   the block must be split into several segments
//   lifting size binary search over the 51-entry table
// a new request is taken only once the last result is in the output register
// a finished beat waits in the output register; the next request is taken
// meanwhile, and its result waits until the previous beat leaves
// reset clears the sequencer and m_tvalid; no clearing pass is needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nr_ldpc_segmentation_params
    import nrldpcseg_pkg::*;
#(
    parameter int RATE_FRAC_BITS = 10
)
(
    input  wire                                                 aclk,
    input  wire                                                 aresetn,
    input  wire                                                 s_tvalid,
    output logic                                                s_tready,
    // tb_size, rate_q10
    input  wire  [((TB_W + RATE_FRAC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                                m_tvalid,
    input  wire                                                 m_tready,
    // crc_len, base_graph, num_segments, seg_bits, info_cols, lift_size,
    // lift_set, block_size, filler_bits, coded_len, out_len
    output logic [OUT_W-1:0]                                    m_tdata
);

    localparam int DW    = TB_W + RATE_FRAC_BITS;
    localparam int DVW   = (RATE_FRAC_BITS > KP_W) ? RATE_FRAC_BITS : KP_W;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int RW    = RATE_FRAC_BITS + 7;

    localparam logic [RATE_FRAC_BITS-1:0] RATE_QUARTER =
        RATE_FRAC_BITS'(1) << (RATE_FRAC_BITS - 2);
    localparam logic [RW-1:0] RATE_BG2_LIMIT = RW'(RATE_BG2_NUM) << RATE_FRAC_BITS;
    localparam logic [CNT_W-1:0] OLEN_STEPS = CNT_W'(DW);
    localparam logic [CNT_W-1:0] SEG_STEPS  = CNT_W'(SEG_W);
    localparam logic [LIFT_IDX_W-1:0] LIFT_LAST = LIFT_IDX_W'(NUM_LIFTS - 1);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DIV_OLEN  = 9'b000000010,
        ST_SEG_SETUP = 9'b000000100,
        ST_DIV_SEGC  = 9'b000001000,
        ST_SEGK_LOAD = 9'b000010000,
        ST_DIV_SEGK  = 9'b000100000,
        ST_KP        = 9'b001000000,
        ST_LIFT      = 9'b010000000,
        ST_FINAL     = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    m_valid_reg, m_valid_next;
    res_t                    res_reg, res_next;
    logic                    rate_zero_reg, rate_zero_next;
    logic [CRC_W-1:0]        crc_reg, crc_next;
    logic [BG_W-1:0]         bg_reg, bg_next;
    logic [KB_W-1:0]         kb_reg, kb_next;
    logic [SEG_W-1:0]        b_reg, b_next;
    logic [NSEG_W-1:0]       nseg_reg, nseg_next;
    logic [KP_W-1:0]         kp_reg, kp_next;
    logic [OLEN_W-1:0]       olen_reg, olen_next;
    logic [LIFT_IDX_W-1:0]   lo_reg, lo_next;
    logic [LIFT_IDX_W-1:0]   hi_reg, hi_next;
    logic [DW-1:0]           quo_reg, quo_next;
    logic [DVW-1:0]          rem_reg, rem_next;
    logic [DVW-1:0]          den_reg, den_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    // request decode
    logic [TB_W-1:0]           in_size;
    logic [RATE_FRAC_BITS-1:0] in_rate;
    logic [CRC_W-1:0]          in_crc;
    logic [RW-1:0]             in_rate100;
    logic                      in_bg2;
    logic [SEG_W-1:0]          in_b;
    logic [KB_W-1:0]           in_kb;

    // shared divider
    logic [DVW:0]   div_trial;
    logic [DVW+1:0] div_diff;
    logic           div_fits;
    logic [DVW-1:0] div_rem_step;
    logic [DW-1:0]  div_quo_step;
    logic           div_inc;
    logic           div_last;

    logic [DW:0]        olen_sum;
    logic [63:0]        olen_wide;
    logic [OLEN_W-1:0]  olen_sat;
    logic [KP_W-1:0]    kcb;
    logic [KP_W-1:0]    kcb_less_crc;
    logic [NSEG_W-1:0]  c_val;
    logic [SEG_W-1:0]   bprime;
    logic [KP_W-1:0]    kp_val;

    logic [LIFT_IDX_W:0]   mid_sum;
    logic [LIFT_IDX_W-1:0] mid;
    logic [KP_W-1:0]       mid_prod;
    logic                  mid_hit;

    logic [LIFT_W-1:0]  fin_z;
    logic [BLK_W-1:0]   fin_blk;
    logic [CODED_W-1:0] fin_coded;
    logic [FILL_W-1:0]  fin_fill;

    assign in_size    = s_tdata[TB_W-1:0];
    assign in_rate    = s_tdata[TB_W +: RATE_FRAC_BITS];
    assign in_crc     = (in_size > TB_CRC_LIMIT) ? CRC_LONG : CRC_SHORT;
    assign in_rate100 = RW'(in_rate) * RW'(RATE_BG2_DEN);
    assign in_bg2     = (in_size < BG2_SIZE_LIMIT)
                     || ((in_size < BG2_RATE_SIZE_LIMIT) && (in_rate100 <= RATE_BG2_LIMIT))
                     || (in_rate <= RATE_QUARTER);
    assign in_b       = SEG_W'(in_size) + SEG_W'(in_crc);

    always_comb begin
        if (!in_bg2) begin
            in_kb = KB_BG1;
        end else if (in_b > KB_LIMIT_10) begin
            in_kb = KB_10;
        end else if (in_b > KB_LIMIT_9) begin
            in_kb = KB_9;
        end else if (in_b > KB_LIMIT_8) begin
            in_kb = KB_8;
        end else begin
            in_kb = KB_6;
        end
    end

    // one restoring step per cycle
    assign div_trial    = {rem_reg, quo_reg[DW-1]};
    assign div_diff     = {1'b0, div_trial} - {2'b00, den_reg};
    assign div_fits     = ~div_diff[DVW+1];
    assign div_rem_step = div_fits ? div_diff[DVW-1:0] : div_trial[DVW-1:0];
    assign div_quo_step = {quo_reg[DW-2:0], div_fits};
    assign div_inc      = (rem_reg != '0);
    assign div_last     = (cnt_reg == CNT_W'(1));

    assign olen_sum  = {1'b0, quo_reg} + (DW + 1)'(div_inc);
    assign olen_wide = 64'(olen_sum);
    assign olen_sat  = (olen_wide > 64'(OUT_LEN_MAX)) ? OUT_LEN_MAX : olen_wide[OLEN_W-1:0];

    assign kcb          = (bg_reg == BG_ONE) ? KCB_BG1 : KCB_BG2;
    assign kcb_less_crc = kcb - KP_W'(crc_reg);
    assign c_val        = quo_reg[NSEG_W-1:0] + NSEG_W'(div_inc);
    assign bprime       = b_reg + SEG_W'(c_val) * SEG_W'(crc_reg);
    assign kp_val       = quo_reg[KP_W-1:0] + KP_W'(div_inc);

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[LIFT_IDX_W:1];
    assign mid_prod = KP_W'(kb_reg) * KP_W'(LIFT_TABLE[mid]);
    assign mid_hit  = (mid_prod >= kp_reg);

    assign fin_z     = LIFT_TABLE[lo_reg];
    assign fin_blk   = (bg_reg == BG_ONE) ? BLK_W'(BLK_MUL_BG1) * BLK_W'(fin_z)
                                          : BLK_W'(BLK_MUL_BG2) * BLK_W'(fin_z);
    assign fin_coded = (bg_reg == BG_ONE) ? CODED_W'(CODED_MUL_BG1) * CODED_W'(fin_z)
                                          : CODED_W'(CODED_MUL_BG2) * CODED_W'(fin_z);
    assign fin_fill  = (fin_blk >= kp_reg) ? FILL_W'(fin_blk - kp_reg) : '0;

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        res_next       = res_reg;
        rate_zero_next = rate_zero_reg;
        crc_next       = crc_reg;
        bg_next        = bg_reg;
        kb_next        = kb_reg;
        b_next         = b_reg;
        nseg_next      = nseg_reg;
        kp_next        = kp_reg;
        olen_next      = olen_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    crc_next       = in_crc;
                    bg_next        = in_bg2 ? BG_TWO : BG_ONE;
                    kb_next        = in_kb;
                    b_next         = in_b;
                    rate_zero_next = (in_rate == '0);
                    if (in_rate == '0) begin
                        olen_next  = OUT_LEN_MAX;
                        state_next = ST_SEG_SETUP;
                    end else begin
                        quo_next   = {in_size, {RATE_FRAC_BITS{1'b0}}};
                        rem_next   = '0;
                        den_next   = DVW'(in_rate);
                        cnt_next   = OLEN_STEPS;
                        state_next = ST_DIV_OLEN;
                    end
                end
            end
            ST_DIV_OLEN, ST_DIV_SEGC, ST_DIV_SEGK: begin
                quo_next = div_quo_step;
                rem_next = div_rem_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (div_last) begin
                    case (state_reg)
                        ST_DIV_OLEN: state_next = ST_SEG_SETUP;
                        ST_DIV_SEGC: state_next = ST_SEGK_LOAD;
                        default:     state_next = ST_KP;
                    endcase
                end
            end
            ST_SEG_SETUP: begin
                if (!rate_zero_reg) begin
                    olen_next = olen_sat;
                end
                if (b_reg < SEG_W'(kcb)) begin
                    nseg_next  = NSEG_W'(1);
                    kp_next    = b_reg[KP_W-1:0];
                    lo_next    = '0;
                    hi_next    = LIFT_LAST;
                    state_next = ST_LIFT;
                end else begin
                    quo_next   = {b_reg, {(DW - SEG_W){1'b0}}};
                    rem_next   = '0;
                    den_next   = DVW'(kcb_less_crc);
                    cnt_next   = SEG_STEPS;
                    state_next = ST_DIV_SEGC;
                end
            end
            ST_SEGK_LOAD: begin
                nseg_next  = c_val;
                quo_next   = {bprime, {(DW - SEG_W){1'b0}}};
                rem_next   = '0;
                den_next   = DVW'(c_val);
                cnt_next   = SEG_STEPS;
                state_next = ST_DIV_SEGK;
            end
            ST_KP: begin
                kp_next    = kp_val;
                lo_next    = '0;
                hi_next    = LIFT_LAST;
                state_next = ST_LIFT;
            end
            ST_LIFT: begin
                if (lo_reg == hi_reg) begin
                    state_next = ST_FINAL;
                end else if (mid_hit) begin
                    hi_next = mid;
                end else begin
                    lo_next = mid + LIFT_IDX_W'(1);
                end
            end
            ST_FINAL: begin
                if (!m_valid_reg || m_tready) begin
                    res_next.pad          = '0;
                    res_next.out_len      = olen_reg;
                    res_next.coded_len    = fin_coded;
                    res_next.filler_bits  = fin_fill;
                    res_next.block_size   = fin_blk;
                    res_next.lift_set     = lift_set_of(fin_z);
                    res_next.lift_size    = fin_z;
                    res_next.info_cols    = kb_reg;
                    res_next.seg_bits     = kp_reg;
                    res_next.num_segments = nseg_reg;
                    res_next.base_graph   = bg_reg;
                    res_next.crc_len      = crc_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg       <= res_next;
        rate_zero_reg <= rate_zero_next;
        crc_reg       <= crc_next;
        bg_reg        <= bg_next;
        kb_reg        <= kb_next;
        b_reg         <= b_next;
        nseg_reg      <= nseg_next;
        kp_reg        <= kp_next;
        olen_reg      <= olen_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        cnt_reg       <= cnt_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

endmodule

`default_nettype wire

// File: src/nrldpcseg_checker.sv
// ----------------------------------------------------------------------------
// nrldpcseg_checker
// port-level checks for the nr ldpc segmentation parameter block, bound to
// the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nr_ldpc_segmentation_params_defines.svh"

module nrldpcseg_checker
    import nrldpcseg_pkg::*;
(
    input wire             aclk,
    input wire             aresetn,
    input wire             s_tvalid,
    input wire             s_tready,
    input wire             m_tvalid,
    input wire             m_tready,
    // crc_len, base_graph, num_segments, seg_bits, info_cols, lift_size,
    // lift_set, block_size, filler_bits, coded_len, out_len
    input wire [OUT_W-1:0] m_tdata
);

    res_t res;

    assign res = m_tdata;

    // stalled result beat holds
    `NLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one request at a time: busy right after an accepted beat
    `NLS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // reset empties the output register
    `NLS_ASSERT_NEXT_RST(a_reset_clears_out, !aresetn, !m_tvalid)

    // derived fields agree with each other
    `NLS_ASSERT_IMPLY(a_fields_agree, m_tvalid, (res.block_size == BLK_W'(res.seg_bits + res.filler_bits)) && ((res.base_graph == BG_ONE) == (res.info_cols == KB_BG1)) && ((res.crc_len == CRC_SHORT) || (res.crc_len == CRC_LONG)))

endmodule

bind nr_ldpc_segmentation_params nrldpcseg_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
